/* hw/rtl/lfra_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Length-framed request acker package
// Shared types and constants for the request parser, the response queue and
// the response serializer.
// ---------------------------------------------------------------------------
package lfra_pkg;

   // Framing constants.
   localparam logic [31:0] MIN_LENGTH   = 32'd10;
   localparam logic [31:0] PREFIX_BYTES = 32'd4;

   // Request type range that is answered.
   localparam logic [7:0] TYPE_FIRST = 8'h01;
   localparam logic [7:0] TYPE_LAST  = 8'h04;

   // Response byte contents.
   localparam logic [7:0] ACK_FLAG        = 8'h80;
   localparam logic [7:0] RESP_LENGTH_LSB = 8'h0a;
   localparam logic [7:0] ZERO_BYTE       = 8'h00;

   // Positions inside the 14-byte response.
   localparam int unsigned RESP_BYTES = 14;
   localparam int unsigned POS_W      = $clog2(RESP_BYTES);
   localparam logic [POS_W-1:0] POS_LENGTH_LSB = POS_W'(3);
   localparam logic [POS_W-1:0] POS_TYPE       = POS_W'(4);
   localparam logic [POS_W-1:0] POS_SEQ3       = POS_W'(6);
   localparam logic [POS_W-1:0] POS_SEQ2       = POS_W'(7);
   localparam logic [POS_W-1:0] POS_SEQ1       = POS_W'(8);
   localparam logic [POS_W-1:0] POS_SEQ0       = POS_W'(9);
   localparam logic [POS_W-1:0] POS_LAST       = POS_W'(RESP_BYTES - 1);

   // Body offsets that are kept; offsets at or past OFF_SKIP are dropped.
   localparam logic [2:0] OFF_TYPE      = 3'd0;
   localparam logic [2:0] OFF_SEQ_FIRST = 3'd2;
   localparam logic [2:0] OFF_SEQ_LAST  = 3'd5;
   localparam logic [2:0] OFF_SKIP      = 3'd6;

   // Response queue size.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One pending response.
   typedef struct packed {
      logic [7:0]  req_type;
      logic [31:0] seq_num;
   } desc_type;

endpackage
`default_nettype wire

/* hw/rtl/lfra_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Length-framed request acker channels
// Valid/ready channels for received request bytes and response bytes.
// ---------------------------------------------------------------------------
interface lfra_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source  (output valid, output rx_byte, input ready);
   modport sink    (input valid, input rx_byte, output ready);
   modport monitor (input valid, input rx_byte, input ready);
endinterface

interface lfra_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       frame_end;

   modport source  (output valid, output tx_byte, output frame_end, input ready);
   modport sink    (input valid, input tx_byte, input frame_end, output ready);
   modport monitor (input valid, input tx_byte, input frame_end, input ready);
endinterface
`default_nettype wire

/* hw/rtl/lfra_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Length-framed request acker front end
// Parses the length prefix and request body and queues one descriptor for
// every complete request with a known type.
// ---------------------------------------------------------------------------
module lfra_front (
   input  wire logic              clock,
   input  wire logic              reset,
   lfra_req_if.sink               req_bus,
   output lfra_pkg::desc_type     push_desc,
   output logic                   push_valid,
   input  wire logic              push_ready
);

   typedef enum logic [1:0] {
      PH_LENGTH,
      PH_BODY,
      PH_HALT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  len_cnt_ff, len_cnt_in;
   logic [23:0] length_ff, length_in;
   logic [31:0] remain_ff, remain_in;
   logic [2:0]  offset_ff, offset_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] seq_ff, seq_in;
   logic        take;
   logic [31:0] full_length;
   logic        body_last;
   logic        type_known;

   // A byte is taken only while the queue can absorb a descriptor.
   assign req_bus.ready = push_ready;
   assign take          = req_bus.valid && push_ready;

   assign full_length = {length_ff, req_bus.rx_byte};
   assign body_last   = (remain_ff == 32'd1);
   assign type_known  = (type_ff >= lfra_pkg::TYPE_FIRST) &&
                        (type_ff <= lfra_pkg::TYPE_LAST);

   // Next-state logic of the parser.
   always_comb begin
      phase_in   = phase_ff;
      len_cnt_in = len_cnt_ff;
      length_in  = length_ff;
      remain_in  = remain_ff;
      offset_in  = offset_ff;
      type_in    = type_ff;
      seq_in     = seq_ff;
      push_valid = 1'b0;
      if (take) begin
         case (phase_ff)
            PH_LENGTH: begin
               length_in  = full_length[23:0];
               len_cnt_in = len_cnt_ff + 2'd1;
               if (len_cnt_ff == 2'd3) begin
                  offset_in = lfra_pkg::OFF_TYPE;
                  type_in   = '0;
                  seq_in    = '0;
                  remain_in = full_length - lfra_pkg::PREFIX_BYTES;
                  if (full_length < lfra_pkg::MIN_LENGTH) begin
                     phase_in = PH_HALT;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (offset_ff == lfra_pkg::OFF_TYPE) begin
                  type_in = req_bus.rx_byte;
               end
               if ((offset_ff >= lfra_pkg::OFF_SEQ_FIRST) &&
                   (offset_ff <= lfra_pkg::OFF_SEQ_LAST)) begin
                  seq_in = {seq_ff[23:0], req_bus.rx_byte};
               end
               if (offset_ff != lfra_pkg::OFF_SKIP) begin
                  offset_in = offset_ff + 3'd1;
               end
               remain_in = remain_ff - 32'd1;
               // The body is at least six bytes, so the type is known here.
               if (body_last) begin
                  push_valid = type_known;
                  phase_in   = PH_LENGTH;
                  len_cnt_in = '0;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   assign push_desc.req_type = type_ff;
   assign push_desc.seq_num  = seq_in;

   // Parser registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LENGTH;
         len_cnt_ff <= '0;
         length_ff  <= '0;
         remain_ff  <= '0;
         offset_ff  <= '0;
         type_ff    <= '0;
         seq_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         len_cnt_ff <= len_cnt_in;
         length_ff  <= length_in;
         remain_ff  <= remain_in;
         offset_ff  <= offset_in;
         type_ff    <= type_in;
         seq_ff     <= seq_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/lfra_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Length-framed request acker response queue
// Small descriptor queue that decouples the parser from the serializer.
// ---------------------------------------------------------------------------
module lfra_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lfra_pkg::desc_type push_desc,
   input  wire logic              push_valid,
   output logic                   push_ready,
   output lfra_pkg::desc_type     pop_desc,
   output logic                   pop_valid,
   input  wire logic              pop_ready
);

   lfra_pkg::desc_type entries_ff [lfra_pkg::QUEUE_DEPTH];
   logic [lfra_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lfra_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lfra_pkg::QCNT_W-1:0] count_ff, count_in;
   logic push_fire;
   logic pop_fire;

   assign push_ready = (count_ff != lfra_pkg::QCNT_W'(lfra_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_desc   = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         if (wr_ptr_ff == lfra_pkg::QPTR_W'(lfra_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + lfra_pkg::QPTR_W'(1);
         end
      end
      if (pop_fire) begin
         if (rd_ptr_ff == lfra_pkg::QPTR_W'(lfra_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + lfra_pkg::QPTR_W'(1);
         end
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + lfra_pkg::QCNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - lfra_pkg::QCNT_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Descriptor storage.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/lfra_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Length-framed request acker back end
// Serializes one queued descriptor into the 14-byte response frame.
// ---------------------------------------------------------------------------
module lfra_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lfra_pkg::desc_type pop_desc,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   lfra_rsp_if.source             rsp_bus
);

   logic                         busy_ff, busy_in;
   logic [lfra_pkg::POS_W-1:0]   pos_ff, pos_in;
   lfra_pkg::desc_type           desc_ff, desc_in;
   logic                         out_fire;
   logic                         at_last;

   assign out_fire  = busy_ff && rsp_bus.ready;
   assign at_last   = (pos_ff == lfra_pkg::POS_LAST);
   // Load a new frame when idle or as the last byte of the current one leaves.
   assign pop_ready = !busy_ff || (out_fire && at_last);

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      desc_in = desc_ff;
      if (out_fire) begin
         pos_in = pos_ff + lfra_pkg::POS_W'(1);
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (pop_ready && pop_valid) begin
         busy_in = 1'b1;
         pos_in  = '0;
         desc_in = pop_desc;
      end
   end

   // Byte selection for the current position of the frame.
   always_comb begin
      case (pos_ff)
         lfra_pkg::POS_LENGTH_LSB: rsp_bus.tx_byte = lfra_pkg::RESP_LENGTH_LSB;
         lfra_pkg::POS_TYPE:       rsp_bus.tx_byte = desc_ff.req_type + lfra_pkg::ACK_FLAG;
         lfra_pkg::POS_SEQ3:       rsp_bus.tx_byte = desc_ff.seq_num[31:24];
         lfra_pkg::POS_SEQ2:       rsp_bus.tx_byte = desc_ff.seq_num[23:16];
         lfra_pkg::POS_SEQ1:       rsp_bus.tx_byte = desc_ff.seq_num[15:8];
         lfra_pkg::POS_SEQ0:       rsp_bus.tx_byte = desc_ff.seq_num[7:0];
         default:                  rsp_bus.tx_byte = lfra_pkg::ZERO_BYTE;
      endcase
   end

   assign rsp_bus.valid     = busy_ff;
   assign rsp_bus.frame_end = at_last;

   // Serializer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

endmodule
`default_nettype wire

/* hw/rtl/length_framed_request_acker_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Length-framed request acker
// Answers length-framed requests of type 1 to 4 with a 14-byte response.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries one received request byte per transaction. Each request
//   is a 4-byte big-endian length followed by length-4 body bytes. A length
//   below 10 halts the parser; later bytes are accepted and dropped until
//   reset.
//   rsp_bus carries one response byte per transaction, frame_end set on the
//   fourteenth byte of each response.
// Timing:
//   The parser takes one byte per cycle while the response queue has room.
//   The first response byte is offered once the descriptor has been written
//   to the queue and loaded into the serializer; frames then stream back to
//   back at one byte per cycle while the receiver is ready. A shortest
//   request is ten bytes in and fourteen out, so the serializer limits it.
// Reset and stalls:
//   Synchronous reset clears the parser, the two-entry response queue and
//   the serializer. When the receiver stalls, the queue fills and req_bus
//   ready drops until a queue entry frees up.
// ---------------------------------------------------------------------------
module length_framed_request_acker_top (
   input  wire logic   clock,
   input  wire logic   reset,
   lfra_req_if.sink    req_bus,
   lfra_rsp_if.source  rsp_bus
);

   lfra_pkg::desc_type push_desc;
   lfra_pkg::desc_type pop_desc;
   logic push_valid;
   logic push_ready;
   logic pop_valid;
   logic pop_ready;

   lfra_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_desc  (push_desc),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   lfra_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_desc  (push_desc),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_desc   (pop_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   lfra_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_desc  (pop_desc),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire

/* hw/rtl/lfra_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Length-framed request acker checker
// Port-level assertions on the response channel, bound to the top level.
// ---------------------------------------------------------------------------
module lfra_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_tx_byte,
   input wire logic       rsp_frame_end
);

   // A stalled response transaction stays offered.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // A stalled response transaction keeps its payload.
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_tx_byte) && $stable(rsp_frame_end))
      else $error("response payload changed while stalled");

   // Nothing is offered right after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response offered right after reset");

   // The closing byte of every response is zero.
   a_end_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_tx_byte == lfra_pkg::ZERO_BYTE)
      else $error("last response byte is not zero");

   // A response cannot start in the cycle after reset releases the input.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && req_valid |=> !rsp_valid)
      else $error("response appeared without a complete request");

endmodule

bind length_framed_request_acker_top lfra_checker u_lfra_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_tx_byte   (rsp_bus.tx_byte),
   .rsp_frame_end (rsp_bus.frame_end)
);
`default_nettype wire

/* test/tb_length_framed_request_acker_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Length-framed request acker testbench
// Feeds framed request bytes through the request channel and checks every
// response byte against a local model of the parser. It starts with a short
// table of directed bytes, then runs random frames with random sender bursts
// and receiver stalls. It ends with a short length word, after which the
// block must stay silent.
// ---------------------------------------------------------------------------
module tb_length_framed_request_acker_top;

   localparam int unsigned CLOCK_HALF    = 4;
   localparam int unsigned RESET_CYCLES  = 11;
   localparam int unsigned RANDOM_ITEMS  = 295;
   localparam logic [31:0] LONG_LENGTH   = 32'h0000_0040;
   localparam int unsigned DRAIN_CYCLES  = 64;
   localparam int unsigned QUIET_LIMIT   = 1000;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam int unsigned DIRECTED_ROWS = 21;

   // Parser phases of the local model.
   typedef enum logic [1:0] {
      SCAN_LENGTH,
      SCAN_BODY,
      SCAN_HALTED
   } scan_phase_type;

   // Receiver stall patterns.
   typedef enum int unsigned {
      SINK_OPEN,
      SINK_HOLD,
      SINK_TOGGLE,
      SINK_COIN
   } sink_mode_type;

   // One expected response byte.
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_end;
   } ack_byte_type;

   // One directed stimulus row; typed rows carry their response literally.
   typedef struct packed {
      logic [7:0]  rx_byte;
      logic        typed;
      logic [7:0]  ack_type;
      logic [31:0] ack_seq;
   } request_row_type;

   logic clock;
   logic reset;

   lfra_req_if req_bus ();
   lfra_rsp_if rsp_bus ();

   length_framed_request_acker_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Model state of the request parser.
   scan_phase_type scan_phase  = SCAN_LENGTH;
   logic [31:0]    scan_index  = '0;
   logic [31:0]    scan_length = '0;
   logic [7:0]     scan_type   = '0;
   logic [31:0]    scan_seq    = '0;

   ack_byte_type    expected_acks [$];
   request_row_type directed_rows [DIRECTED_ROWS];

   // Handshake samples taken mid-cycle, used at the following rising edge.
   bit         req_take;
   bit         rsp_take;
   logic [7:0] rsp_byte_seen;
   logic       rsp_end_seen;

   int unsigned mismatches   = 0;
   int unsigned quiet_cycles = 0;
   int unsigned burst_left   = 0;

   // Clock.
   initial clock = 1'b0;
   always #(CLOCK_HALF) clock = ~clock;

   // Sample both channels away from the active edge.
   always @(negedge clock) begin
      req_take      = ((req_bus.valid && req_bus.ready) === 1'b1) && !reset;
      rsp_take      = ((rsp_bus.valid && rsp_bus.ready) === 1'b1) && !reset;
      rsp_byte_seen = rsp_bus.tx_byte;
      rsp_end_seen  = rsp_bus.frame_end;
   end

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   // Queue the fourteen bytes of one acknowledge frame.
   task automatic queue_ack(input logic [7:0] ack_type, input logic [31:0] seq);
      ack_byte_type ab;
      for (int unsigned k = 0; k < lfra_pkg::RESP_BYTES; k++) begin
         case (k)
            lfra_pkg::POS_LENGTH_LSB: ab.tx_byte = lfra_pkg::RESP_LENGTH_LSB;
            lfra_pkg::POS_TYPE:       ab.tx_byte = ack_type;
            lfra_pkg::POS_SEQ3:       ab.tx_byte = seq[31:24];
            lfra_pkg::POS_SEQ2:       ab.tx_byte = seq[23:16];
            lfra_pkg::POS_SEQ1:       ab.tx_byte = seq[15:8];
            lfra_pkg::POS_SEQ0:       ab.tx_byte = seq[7:0];
            default:                  ab.tx_byte = lfra_pkg::ZERO_BYTE;
         endcase
         ab.frame_end = (k == lfra_pkg::RESP_BYTES - 1);
         expected_acks.insert(expected_acks.size(), ab);
      end
   endtask

   // Advance the parser model by one accepted byte; answered frames are
   // queued only when record is set.
   task automatic scan_request_byte(input logic [7:0] value, input bit record);
      case (scan_phase)
         SCAN_LENGTH: begin
            scan_length = {scan_length[23:0], value};
            scan_index++;
            if (scan_index >= lfra_pkg::PREFIX_BYTES) begin
               scan_index = '0;
               if (scan_length < lfra_pkg::MIN_LENGTH) begin
                  scan_phase = SCAN_HALTED;
               end else begin
                  scan_phase = SCAN_BODY;
                  scan_type  = '0;
                  scan_seq   = '0;
               end
            end
         end
         SCAN_BODY: begin
            if (scan_index == 0) begin
               scan_type = value;
            end else if (scan_index >= 2 && scan_index <= 5) begin
               scan_seq = {scan_seq[23:0], value};
            end
            scan_index++;
            if (scan_index >= scan_length - lfra_pkg::PREFIX_BYTES) begin
               if (record && scan_type >= lfra_pkg::TYPE_FIRST &&
                   scan_type <= lfra_pkg::TYPE_LAST) begin
                  queue_ack(scan_type + lfra_pkg::ACK_FLAG, scan_seq);
               end
               scan_phase  = SCAN_LENGTH;
               scan_index  = '0;
               scan_length = '0;
            end
         end
         default: begin
            // Halted: the byte is dropped.
         end
      endcase
   endtask

   // Send one request byte in the current burst and wait for the transaction.
   task automatic push_request_byte(input logic [7:0] value, input bit typed,
                                    input logic [7:0] typed_ack,
                                    input logic [31:0] typed_seq);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= value;
      do @(posedge clock); while (!req_take);
      burst_left--;
      scan_request_byte(value, !typed);
      if (typed) begin
         queue_ack(typed_ack, typed_seq);
      end
   endtask

   // Send a whole frame: the length word, the type byte, then random bytes.
   task automatic send_frame(input logic [31:0] len, input logic [7:0] kind);
      logic [7:0] value;
      for (int unsigned k = 0; k < len; k++) begin
         if (k < lfra_pkg::PREFIX_BYTES) begin
            value = len[31 - 8 * k -: 8];
         end else if (k == lfra_pkg::PREFIX_BYTES) begin
            value = kind;
         end else begin
            value = 8'($urandom_range(0, 255));
         end
         push_request_byte(value, 1'b0, lfra_pkg::ZERO_BYTE, '0);
      end
   endtask

   // Mostly answered types, the rest unknown ones including both extremes.
   function automatic logic [7:0] pick_type();
      if ($urandom_range(0, 9) < 8) begin
         return 8'($urandom_range(lfra_pkg::TYPE_FIRST, lfra_pkg::TYPE_LAST));
      end
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return lfra_pkg::TYPE_LAST + 8'd1;
         2:       return 8'hff;
         default: return 8'($urandom_range(lfra_pkg::TYPE_LAST + 1, 255));
      endcase
   endfunction

   // Mostly frames near the minimum size, some with a longer payload tail.
   function automatic logic [31:0] pick_length();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6) begin
         return $urandom_range(lfra_pkg::MIN_LENGTH, lfra_pkg::MIN_LENGTH + 4);
      end else if (r < 9) begin
         return $urandom_range(lfra_pkg::MIN_LENGTH + 5, 30);
      end
      return $urandom_range(31, 80);
   endfunction

   // Response checker.
   always @(posedge clock) begin : check_acks
      ack_byte_type want;
      if (rsp_take) begin
         if (expected_acks.size() == 0) begin
            flag_mismatch($sformatf("unexpected response byte %02h frame_end %0b",
                                    rsp_byte_seen, rsp_end_seen));
         end else begin
            want = expected_acks[0];
            expected_acks.delete(0);
            if (want.tx_byte !== rsp_byte_seen) begin
               flag_mismatch($sformatf("tx_byte: expected %02h, got %02h",
                                       want.tx_byte, rsp_byte_seen));
            end
            if (want.frame_end !== rsp_end_seen) begin
               flag_mismatch($sformatf("frame_end: expected %0b, got %0b",
                                       want.frame_end, rsp_end_seen));
            end
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (reset || req_take || rsp_take) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_length_framed_request_acker_top: done, errors");
            $finish;
         end
      end
   end

   // Receiver: runs of open, held, toggling and coin-flip ready.
   initial begin : rsp_ready_pattern
      sink_mode_type mode;
      int unsigned   run;
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         mode = sink_mode_type'($urandom_range(SINK_OPEN, SINK_COIN));
         case (mode)
            SINK_OPEN: run = $urandom_range(8, 60);
            SINK_HOLD: run = $urandom_range(1, 12);
            default:   run = $urandom_range(4, 30);
         endcase
         for (int unsigned c = 0; c < run; c++) begin
            case (mode)
               SINK_OPEN:   rsp_bus.ready <= 1'b1;
               SINK_HOLD:   rsp_bus.ready <= 1'b0;
               SINK_TOGGLE: rsp_bus.ready <= c[0];
               default:     rsp_bus.ready <= 1'($urandom_range(0, 1));
            endcase
            @(posedge clock);
         end
      end
   end

   // Stimulus.
   initial begin : stimulus
      int unsigned random_items;
      int unsigned long_at;
      bit          long_sent;
      bit          pressure_done;
      logic [31:0] len;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;

      // Minimum frame of type 1 with all-ones status and sequence, then an
      // unknown all-ones type with one payload byte.
      directed_rows = '{
         '{8'h00, 1'b0, 8'h00, 32'h0},
         '{8'h00, 1'b0, 8'h00, 32'h0},
         '{8'h00, 1'b0, 8'h00, 32'h0},
         '{8'h0a, 1'b0, 8'h00, 32'h0},
         '{8'h01, 1'b0, 8'h00, 32'h0},
         '{8'hff, 1'b0, 8'h00, 32'h0},
         '{8'hff, 1'b0, 8'h00, 32'h0},
         '{8'hff, 1'b0, 8'h00, 32'h0},
         '{8'hff, 1'b0, 8'h00, 32'h0},
         '{8'hff, 1'b1, 8'h81, 32'hffff_ffff},
         '{8'h00, 1'b0, 8'h00, 32'h0},
         '{8'h00, 1'b0, 8'h00, 32'h0},
         '{8'h00, 1'b0, 8'h00, 32'h0},
         '{8'h0b, 1'b0, 8'h00, 32'h0},
         '{8'hff, 1'b0, 8'h00, 32'h0},
         '{8'h00, 1'b0, 8'h00, 32'h0},
         '{8'h00, 1'b0, 8'h00, 32'h0},
         '{8'h00, 1'b0, 8'h00, 32'h0},
         '{8'h00, 1'b0, 8'h00, 32'h0},
         '{8'h00, 1'b0, 8'h00, 32'h0},
         '{8'h5a, 1'b0, 8'h00, 32'h0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         push_request_byte(directed_rows[r].rx_byte, directed_rows[r].typed,
                           directed_rows[r].ack_type, directed_rows[r].ack_seq);
      end

      // Random frames, with one long frame and one full drain along the way.
      random_items  = 0;
      long_at       = $urandom_range(40, RANDOM_ITEMS - 40);
      long_sent     = 1'b0;
      pressure_done = 1'b0;
      while (random_items < RANDOM_ITEMS) begin
         if (!long_sent && random_items >= long_at) begin
            send_frame(LONG_LENGTH,
                       8'($urandom_range(lfra_pkg::TYPE_FIRST, lfra_pkg::TYPE_LAST)));
            random_items += LONG_LENGTH;
            long_sent = 1'b1;
         end
         if (!pressure_done && random_items >= RANDOM_ITEMS / 2) begin
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (expected_acks.size() != 0);
            pressure_done = 1'b1;
         end
         len = pick_length();
         send_frame(len, pick_type());
         random_items += len;
      end

      // A short length word halts the parser; the frame after it is dropped.
      push_request_byte(8'h00, 1'b0, lfra_pkg::ZERO_BYTE, '0);
      push_request_byte(8'h00, 1'b0, lfra_pkg::ZERO_BYTE, '0);
      push_request_byte(8'h00, 1'b0, lfra_pkg::ZERO_BYTE, '0);
      push_request_byte(8'($urandom_range(0, lfra_pkg::MIN_LENGTH - 1)), 1'b0,
                        lfra_pkg::ZERO_BYTE, '0);
      send_frame(lfra_pkg::MIN_LENGTH, lfra_pkg::TYPE_FIRST);
      req_bus.valid <= 1'b0;

      // Drain, then give stray bytes time to show up.
      while (expected_acks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0) begin
         $display("tb_length_framed_request_acker_top: done, clean");
      end else begin
         $display("tb_length_framed_request_acker_top: done, errors");
      end
      $finish;
   end

endmodule
